// File: hw/rtl/skip_literal_rle_bitmap_decoder_top_assert.svh
// Assertion macros for the skip/literal decoder.
`ifndef SKIP_LITERAL_RLE_BITMAP_DECODER_TOP_ASSERT_SVH
`define SKIP_LITERAL_RLE_BITMAP_DECODER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SLRD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define SLRD_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define SLRD_ASSERT(label, prop, msg)
`define SLRD_NEVER(label, cond, msg)
`endif

`endif

// File: hw/rtl/slrd_pkg.sv
`default_nettype none
package slrd_pkg;

    localparam int AW     = 25;
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 14;

    localparam logic [CFG_IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ROW_PITCH    = 2'd2;

    localparam logic [12:0] WIDTH_RESET  = 13'd8;
    localparam logic [12:0] HEIGHT_RESET = 13'd1;
    localparam logic [13:0] PITCH_RESET  = 14'd8;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_COUNT,
        PH_LIT,
        PH_DROP
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic norm;
        logic accept;
        logic fill_step;
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   byte_zero;
        logic   fill_end;
        logic   slot_free;
        logic   norm_pending;
    } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/skip_literal_rle_bitmap_decoder_top.sv
// Skip/literal run-length decoder: takes one compressed byte per beat and
// writes spans into the frame buffer address space. Count bytes and literal
// pixel bytes are taken one per cycle while the output beat is free, each
// literal outside the drop phase giving one single-pixel beat. A nonzero
// blank count is accepted and then emits its row segments one at a time
// while the output beat is free, during which input stays stalled; a single
// output register is shared by both paths. After configuration writes, the
// first byte offered is held off while the position is moved back inside the
// new image bounds.
`default_nettype none
`include "skip_literal_rle_bitmap_decoder_top_assert.svh"
module skip_literal_rle_bitmap_decoder_top #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_PITCH  = 8192
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [slrd_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [slrd_pkg::CFG_DW-1:0] cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [7:0]                  code_byte,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [slrd_pkg::AW-1:0]          start_address,
    output logic [7:0]                       span_length,
    output logic                             is_fill,
    output logic [7:0]                       pixel_index,
    output logic                             last_of_run,
    output logic                             image_done
);
    import slrd_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int PMAX = (MAX_PITCH > MAX_WIDTH) ? MAX_PITCH : MAX_WIDTH;
    localparam int PW   = $clog2(PMAX + 1);

    cmd_t          cmd;
    sts_t          dp_sts;
    sts_t          sts;
    logic          norm_pending;
    logic [WW-1:0] eff_width;
    logic [HW-1:0] eff_height;
    logic [PW-1:0] eff_pitch;

    always_comb
    begin
        sts              = dp_sts;
        sts.norm_pending = norm_pending;
    end

    slrd_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PITCH  (MAX_PITCH),
        .WW         (WW),
        .HW         (HW),
        .PW         (PW)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .norm_clear   (cmd.norm),
        .norm_pending (norm_pending),
        .eff_width    (eff_width),
        .eff_height   (eff_height),
        .eff_pitch    (eff_pitch)
    );

    slrd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    slrd_dp #(
        .WW (WW),
        .HW (HW),
        .PW (PW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (dp_sts),
        .eff_width     (eff_width),
        .eff_height    (eff_height),
        .eff_pitch     (eff_pitch),
        .code_byte     (code_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .start_address (start_address),
        .span_length   (span_length),
        .is_fill       (is_fill),
        .pixel_index   (pixel_index),
        .last_of_run   (last_of_run),
        .image_done    (image_done)
    );

    `SLRD_ASSERT(a_done_ends_run, out_valid && image_done |-> last_of_run, "image end mid run")
    `SLRD_ASSERT(a_lit_one_pixel, out_valid && !is_fill |-> span_length == 8'd1, "wide literal")
    `SLRD_ASSERT(a_fill_zero_pix, out_valid && is_fill |-> pixel_index == 8'd0, "fill with pixel")
    `SLRD_NEVER(a_no_overwrite, cmd.fill_step && out_valid && out_stall, "fill over held beat")

endmodule
`default_nettype wire

// File: hw/rtl/slrd_cfg.sv
`default_nettype none
module slrd_cfg #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_PITCH  = 8192,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int PW = $clog2(((MAX_PITCH > MAX_WIDTH) ? MAX_PITCH : MAX_WIDTH) + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [slrd_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [slrd_pkg::CFG_DW-1:0] cfg_data,
    input  wire logic                       norm_clear,
    output logic                            norm_pending,
    output logic [WW-1:0]                   eff_width,
    output logic [HW-1:0]                   eff_height,
    output logic [PW-1:0]                   eff_pitch
);
    import slrd_pkg::*;

    logic [12:0]   width_reg;
    logic [12:0]   height_reg;
    logic [13:0]   pitch_reg;
    logic          norm_reg;
    logic          wr;
    logic [PW-1:0] pitch_clip;

    assign cfg_ready    = 1'b1;
    assign wr           = cfg_valid && cfg_ready;
    assign norm_pending = norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            pitch_reg  <= PITCH_RESET;
            norm_reg   <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                norm_reg <= 1'b1;
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[12:0];
                    CFG_ROW_PITCH:    pitch_reg  <= cfg_data;
                    default:          ;
                endcase
            end
            else if (norm_clear)
            begin
                norm_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (width_reg < 13'd8)
            eff_width = WW'(8);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_reg);
    end

    always_comb
    begin
        if (height_reg == 13'd0)
            eff_height = HW'(1);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            eff_height = HW'(MAX_HEIGHT);
        else
            eff_height = HW'(height_reg);
    end

    always_comb
    begin
        if (32'(pitch_reg) > 32'(MAX_PITCH))
            pitch_clip = PW'(MAX_PITCH);
        else
            pitch_clip = PW'(pitch_reg);
        if (pitch_clip < PW'(eff_width))
            eff_pitch = PW'(eff_width);
        else
            eff_pitch = pitch_clip;
    end

endmodule
`default_nettype wire

// File: hw/rtl/slrd_ctrl.sv
`default_nettype none
module slrd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire slrd_pkg::sts_t sts,
    output slrd_pkg::cmd_t     cmd
);
    import slrd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   can_take;

    assign can_take = in_valid && !sts.norm_pending && sts.slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (can_take && sts.phase == PH_BLANK && !sts.byte_zero)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (sts.slot_free && sts.fill_end)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // position is brought inside the image only once a byte is offered,
    // so it sees the final register values of a configuration sequence
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = sts.norm_pending || !sts.slot_free;
                cmd.norm   = sts.norm_pending && in_valid;
                cmd.accept = can_take;
            end
            ST_FILL:
            begin
                cmd.fill_step = sts.slot_free;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/slrd_dp.sv
`default_nettype none
module slrd_dp #(
    parameter int WW = 13,
    parameter int HW = 13,
    parameter int PW = 14
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire slrd_pkg::cmd_t        cmd,
    output slrd_pkg::sts_t             sts,
    input  wire logic [WW-1:0]         eff_width,
    input  wire logic [HW-1:0]         eff_height,
    input  wire logic [PW-1:0]         eff_pitch,
    input  wire logic [7:0]            code_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [slrd_pkg::AW-1:0]    start_address,
    output logic [7:0]                 span_length,
    output logic                       is_fill,
    output logic [7:0]                 pixel_index,
    output logic                       last_of_run,
    output logic                       image_done
);
    import slrd_pkg::*;

    localparam int CMP = (WW > 8) ? WW : 8;

    phase_t        phase_reg,    phase_next;
    logic [7:0]    run_left_reg, run_left_next;
    logic [7:0]    cnt_reg,      cnt_next;
    logic [WW-1:0] column_reg,   column_next;
    logic [HW-1:0] row_reg,      row_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic          out_valid_reg;

    logic          load;
    logic [AW-1:0] o_addr;
    logic [7:0]    o_len;
    logic          o_fill;
    logic [7:0]    o_pix;
    logic          o_last;
    logic          o_done;

    logic          slot_free;
    logic [WW-1:0] rem;
    logic          fill_row_end;
    logic          fill_done;
    logic          fill_end;
    logic [7:0]    fill_len;
    logic [WW-1:0] col_inc;
    logic          lit_row_end;
    logic          lit_done;
    logic [HW:0]   row_inc;
    logic          row_last;
    logic [AW-1:0] next_base;
    logic [7:0]    rl_after;

    assign slot_free    = !out_valid_reg || !out_stall;
    assign rem          = eff_width - column_reg;
    assign fill_row_end = CMP'(rem) <= CMP'(cnt_reg);
    assign row_inc      = (HW+1)'(row_reg) + (HW+1)'(1);
    assign row_last     = row_inc >= (HW+1)'(eff_height);
    assign fill_done    = fill_row_end && row_last;
    assign fill_end     = fill_done || (CMP'(rem) >= CMP'(cnt_reg));
    assign fill_len     = fill_row_end ? 8'(rem) : cnt_reg;
    assign col_inc      = column_reg + WW'(1);
    assign lit_row_end  = col_inc >= eff_width;
    assign lit_done     = lit_row_end && row_last;
    assign next_base    = row_base_reg + AW'(eff_pitch);
    assign rl_after     = (run_left_reg != 8'd0) ? run_left_reg - 8'd1 : 8'd0;

    always_comb
    begin
        sts.phase        = phase_reg;
        sts.byte_zero    = code_byte == 8'd0;
        sts.fill_end     = fill_end;
        sts.slot_free    = slot_free;
        sts.norm_pending = 1'b0;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        run_left_next = run_left_reg;
        cnt_next      = cnt_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        cur_addr_next = cur_addr_reg;
        load          = 1'b0;
        o_addr        = cur_addr_reg;
        o_len         = 8'd1;
        o_fill        = 1'b0;
        o_pix         = code_byte;
        o_last        = 1'b1;
        o_done        = 1'b0;

        if (cmd.norm)
        begin
            if (column_reg >= eff_width)
            begin
                if (row_inc >= (HW+1)'(eff_height))
                begin
                    column_next   = '0;
                    row_next      = '0;
                    row_base_next = '0;
                    cur_addr_next = '0;
                end
                else
                begin
                    column_next   = '0;
                    row_next      = HW'(row_inc);
                    row_base_next = next_base;
                    cur_addr_next = next_base;
                end
            end
            else if (row_reg >= eff_height)
            begin
                column_next   = '0;
                row_next      = '0;
                row_base_next = '0;
                cur_addr_next = '0;
            end
        end
        else if (cmd.fill_step)
        begin
            load     = 1'b1;
            o_len    = fill_len;
            o_fill   = 1'b1;
            o_pix    = 8'd0;
            o_last   = fill_end;
            o_done   = fill_done;
            cnt_next = cnt_reg - fill_len;
            if (fill_done)
            begin
                column_next   = '0;
                row_next      = '0;
                row_base_next = '0;
                cur_addr_next = '0;
            end
            else if (fill_row_end)
            begin
                column_next   = '0;
                row_next      = HW'(row_inc);
                row_base_next = next_base;
                cur_addr_next = next_base;
            end
            else
            begin
                column_next   = column_reg + WW'(fill_len);
                cur_addr_next = cur_addr_reg + AW'(fill_len);
            end
            if (fill_end)
                phase_next = fill_done ? PH_BLANK : PH_COUNT;
        end
        else if (cmd.accept)
        begin
            case (phase_reg)
                PH_BLANK:
                begin
                    if (code_byte == 8'd0)
                        phase_next = PH_COUNT;
                    else
                        cnt_next = code_byte;
                end
                PH_COUNT:
                begin
                    if (code_byte == 8'd0)
                        phase_next = PH_BLANK;
                    else
                    begin
                        run_left_next = code_byte;
                        phase_next    = PH_LIT;
                    end
                end
                PH_LIT:
                begin
                    load          = 1'b1;
                    o_done        = lit_done;
                    run_left_next = rl_after;
                    if (lit_done)
                    begin
                        column_next   = '0;
                        row_next      = '0;
                        row_base_next = '0;
                        cur_addr_next = '0;
                    end
                    else if (lit_row_end)
                    begin
                        column_next   = '0;
                        row_next      = HW'(row_inc);
                        row_base_next = next_base;
                        cur_addr_next = next_base;
                    end
                    else
                    begin
                        column_next   = col_inc;
                        cur_addr_next = cur_addr_reg + AW'(1);
                    end
                    if (rl_after == 8'd0)
                        phase_next = PH_BLANK;
                    else
                        phase_next = lit_done ? PH_DROP : PH_LIT;
                end
                PH_DROP:
                begin
                    run_left_next = rl_after;
                    if (rl_after == 8'd0)
                        phase_next = PH_BLANK;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BLANK;
            run_left_reg  <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            cur_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            run_left_reg  <= run_left_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            row_base_reg  <= row_base_next;
            cur_addr_reg  <= cur_addr_next;
            out_valid_reg <= load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        if (load)
        begin
            start_address <= o_addr;
            span_length   <= o_len;
            is_fill       <= o_fill;
            pixel_index   <= o_pix;
            last_of_run   <= o_last;
            image_done    <= o_done;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// File: tb/tb_skip_literal_rle_bitmap_decoder_top.sv
`timescale 1ns / 100ps

module tb_skip_literal_rle_bitmap_decoder_top;
    import slrd_pkg::*;

    localparam int unsigned WIDTH_CAP  = 4096;
    localparam int unsigned HEIGHT_CAP = 4096;
    localparam int unsigned PITCH_CAP  = 8192;

    typedef struct packed {
        logic [AW-1:0] start_address;
        logic [7:0]    span_length;
        logic          is_fill;
        logic [7:0]    pixel_index;
        logic          last_of_run;
        logic          image_done;
    } span_t;

    class span_scoreboard;
        span_t          expected_spans[$];
        int unsigned    faults;
        int unsigned    width_reg;
        int unsigned    height_reg;
        int unsigned    pitch_reg;
        phase_t         phase;
        int unsigned    column;
        int unsigned    row;
        int unsigned    run_left;
        logic [AW-1:0]  row_base;

        function new();
            faults     = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            pitch_reg  = PITCH_RESET;
            phase      = PH_BLANK;
            run_left   = 0;
            home();
        endfunction

        function void home();
            column   = 0;
            row      = 0;
            row_base = '0;
        endfunction

        function void step_row(int unsigned pitch);
            column   = 0;
            row++;
            row_base = row_base + AW'(pitch);
        endfunction

        function span_t make_span(int unsigned len, logic fill, logic [7:0] pix);
            span_t s;
            s.start_address = row_base + AW'(column);
            s.span_length   = 8'(len);
            s.is_fill       = fill;
            s.pixel_index   = pix;
            s.last_of_run   = 1'b0;
            s.image_done    = 1'b0;
            return s;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  width_reg  = val[12:0];
                CFG_IMAGE_HEIGHT: height_reg = val[12:0];
                CFG_ROW_PITCH:    pitch_reg  = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_spans.size();
        endfunction

        function void accept_code(logic [7:0] code);
            int unsigned w;
            int unsigned h;
            int unsigned p;
            int unsigned left;
            int unsigned len;
            bit          finished;
            span_t       spans[$];
            span_t       s;
            w = (width_reg < 8) ? 8 : ((width_reg > WIDTH_CAP) ? WIDTH_CAP : width_reg);
            h = (height_reg < 1) ? 1 : ((height_reg > HEIGHT_CAP) ? HEIGHT_CAP : height_reg);
            p = (pitch_reg > PITCH_CAP) ? PITCH_CAP : pitch_reg;
            if (p < w)
                p = w;
            if (column >= w)
                step_row(p);
            if (row >= h)
                home();
            case (phase)
                PH_BLANK:
                begin
                    left     = code;
                    finished = 1'b0;
                    while (left > 0)
                    begin
                        len = w - column;
                        if (len > left)
                            len = left;
                        s = make_span(len, 1'b1, 8'd0);
                        column += len;
                        left   -= len;
                        if (column >= w)
                            step_row(p);
                        if (row >= h)
                        begin
                            s.image_done = 1'b1;
                            home();
                            finished = 1'b1;
                            left     = 0;
                        end
                        spans.push_back(s);
                    end
                    if (spans.size() > 0)
                        spans[spans.size() - 1].last_of_run = 1'b1;
                    phase = finished ? PH_BLANK : PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (code == 8'd0)
                        phase = PH_BLANK;
                    else
                    begin
                        run_left = code;
                        phase    = PH_LIT;
                    end
                end
                PH_LIT:
                begin
                    finished = (column + 1 >= w) && (row + 1 >= h);
                    s = make_span(1, 1'b0, code);
                    s.last_of_run = 1'b1;
                    s.image_done  = finished;
                    spans.push_back(s);
                    column++;
                    if (column >= w)
                        step_row(p);
                    if (run_left > 0)
                        run_left--;
                    if (finished)
                    begin
                        home();
                        phase = (run_left > 0) ? PH_DROP : PH_BLANK;
                    end
                    else
                        phase = (run_left > 0) ? PH_LIT : PH_BLANK;
                end
                default:
                begin
                    if (run_left > 0)
                        run_left--;
                    if (run_left == 0)
                        phase = PH_BLANK;
                end
            endcase
            foreach (spans[i])
                expected_spans.push_back(spans[i]);
        endfunction

        function void check_span(span_t got);
            span_t want;
            if (expected_spans.size() == 0)
            begin
                faults++;
                $error("unexpected span at address %0d", got.start_address);
                return;
            end
            want = expected_spans.pop_front();
            if (got.start_address !== want.start_address)
            begin
                faults++;
                $error("start_address: expected %0d, got %0d",
                       want.start_address, got.start_address);
            end
            if (got.span_length !== want.span_length)
            begin
                faults++;
                $error("span_length: expected %0d, got %0d", want.span_length, got.span_length);
            end
            if (got.is_fill !== want.is_fill)
            begin
                faults++;
                $error("is_fill: expected %0d, got %0d", want.is_fill, got.is_fill);
            end
            if (got.pixel_index !== want.pixel_index)
            begin
                faults++;
                $error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                faults++;
                $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
            end
            if (got.image_done !== want.image_done)
            begin
                faults++;
                $error("image_done: expected %0d, got %0d", want.image_done, got.image_done);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        code_byte;
    logic              out_valid;
    logic              out_stall;
    logic [AW-1:0]     start_address;
    logic [7:0]        span_length;
    logic              is_fill;
    logic [7:0]        pixel_index;
    logic              last_of_run;
    logic              image_done;

    bit                calm;
    bit                hold_req;
    span_t             seen_span;
    span_scoreboard    book = new();

    skip_literal_rle_bitmap_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .code_byte     (code_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .start_address (start_address),
        .span_length   (span_length),
        .is_fill       (is_fill),
        .pixel_index   (pixel_index),
        .last_of_run   (last_of_run),
        .image_done    (image_done)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_span.start_address = start_address;
            seen_span.span_length   = span_length;
            seen_span.is_fill       = is_fill;
            seen_span.pixel_index   = pixel_index;
            seen_span.last_of_run   = last_of_run;
            seen_span.image_done    = image_done;
            book.check_span(seen_span);
        end
    end

    task automatic send_code(input logic [7:0] code);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        code_byte <= code;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        book.accept_code(code);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // pitch first, width last, so a shrink mid-image wraps with the new pitch
    task automatic configure(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h,
                             input logic [CFG_DW-1:0] p);
        logic [CFG_IW-1:0] idx[3];
        logic [CFG_DW-1:0] val[3];
        idx = '{CFG_ROW_PITCH, CFG_IMAGE_HEIGHT, CFG_IMAGE_WIDTH};
        val = '{p, h, w};
        settle();
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            book.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed: byte kind follows the predicted phase
    task automatic feed_stream(input int unsigned n_codes, input int unsigned blank_max);
        int unsigned pick;
        repeat (n_codes)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_code(8'($urandom_range(0, 255)));
            else
                case (book.phase)
                    PH_BLANK:
                        send_code(pick < 18 ? 8'd0 :
                                  pick < 26 ? 8'd255 : 8'($urandom_range(1, blank_max)));
                    PH_COUNT:
                        send_code(pick < 18 ? 8'd0 :
                                  pick < 26 ? 8'($urandom_range(15, 40)) :
                                              8'($urandom_range(1, 12)));
                    default:
                        send_code(8'($urandom_range(0, 255)));
                endcase
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_IMAGE_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        code_byte = 8'd0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: one row of 8 pixels
        send_code(8'd0);
        send_code(8'd0);
        send_code(8'd3);
        send_code(8'd2);
        send_code(8'h00);
        send_code(8'hFF);
        send_code(8'd255);
        send_code(8'd7);
        send_code(8'd3);
        send_code(8'hA5);
        send_code(8'h5A);
        send_code(8'h3C);

        configure(14'd8, 14'd2, 14'd10);
        send_code(8'd255);
        send_code(8'd4);
        send_code(8'd1);
        send_code(8'h81);
        send_code(8'd5);

        // geometry shrinks and grows again while mid-row
        configure(14'd20, 14'd4, 14'd24);
        send_code(8'd15);
        send_code(8'd0);
        configure(14'd8, 14'd2, 14'd10);
        send_code(8'd3);
        configure(14'd20, 14'd4, 14'd24);
        send_code(8'd70);
        send_code(8'd0);
        configure(14'd8, 14'd2, 14'd10);
        send_code(8'd9);

        configure(14'd0, 14'd0, 14'd0);
        feed_stream(15, 12);
        configure(14'd13, 14'd3, 14'd5);
        hold_req <= 1'b1;
        feed_stream(22, 40);
        configure(14'd16383, 14'd16383, 14'd16383);
        feed_stream(10, 255);
        configure(14'd10, 14'd5, 14'd16);
        calm = 1'b1;
        feed_stream(25, 30);
        calm = 1'b0;
        configure(14'd24, 14'd3, 14'd30);
        feed_stream(25, 60);

        settle();
        repeat (12) @(posedge clk);
        if (book.faults == 0 && book.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            if (book.pending() != 0)
                $error("%0d spans never arrived", book.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: skip_literal_rle_bitmap_decoder_top.f
+incdir+hw/rtl
hw/rtl/slrd_pkg.sv
hw/rtl/slrd_cfg.sv
hw/rtl/slrd_ctrl.sv
hw/rtl/slrd_dp.sv
hw/rtl/skip_literal_rle_bitmap_decoder_top.sv
tb/tb_skip_literal_rle_bitmap_decoder_top.sv
